// ----- hw/rtl/mfp_pkg.sv -----
// mfp_pkg: shared types and byte codes for the measurement frame parser.
// Used by mfp_step and measurement_frame_parser; depends on nothing.

package mfp_pkg;

   typedef enum logic [1:0] {
      MODE_MENU   = 2'd0,
      MODE_METER  = 2'd1,
      MODE_LEVEL  = 2'd2,
      MODE_RANGER = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_WAIT_START = 2'd0,
      PHASE_WAIT_SIGN  = 2'd1,
      PHASE_CHUNK      = 2'd2
   } phase_type;

   localparam logic [7:0] BYTE_FRAME_MARK = 8'd0;
   localparam logic [7:0] BYTE_SIGN_PLUS  = 8'd1;
   localparam logic [7:0] BYTE_SIGN_MINUS = 8'd2;
   localparam logic [7:0] BYTE_METER_EXIT = 8'd3;
   localparam logic [7:0] BYTE_MENU_MAX   = 8'd3;
   localparam logic [7:0] BYTE_LEVEL_EMIT = 8'd50;
   localparam logic [7:0] BYTE_LEVEL_EXIT = 8'd100;
   localparam logic [7:0] BYTE_RANGER_REQ = 8'd1;
   localparam logic [7:0] BYTE_RANGER_EXIT = 8'd2;

   localparam logic KIND_METER = 1'b0;
   localparam logic KIND_LEVEL = 1'b1;

   // Narrow control state carried between the step logic and the top level.
   typedef struct packed {
      mode_type  mode;
      phase_type phase;
      logic      sign_minus;
      logic      skip_next;
   } frame_ctl_type;

   // One result beat.
   typedef struct packed {
      mode_type    mode;
      logic        measure_valid;
      logic        measure_kind;
      logic [31:0] measure_value;
      logic        ranger_request;
   } result_type;

endpackage

// ----- hw/rtl/mfp_step.sv -----
// mfp_step: next state and result for one received byte.
// Depends on mfp_pkg; purely combinational, driven from the top level's input register.

module mfp_step #(
   parameter int SUM_BITS   = 24,
   parameter int TOTAL_BITS = 32
) (
   input  logic [7:0]            rx_byte,
   input  mfp_pkg::frame_ctl_type ctl,
   input  logic [SUM_BITS-1:0]   chunk_sum,
   input  logic [TOTAL_BITS-1:0] running_total,
   output mfp_pkg::frame_ctl_type ctl_next,
   output logic [SUM_BITS-1:0]   chunk_sum_next,
   output logic [TOTAL_BITS-1:0] running_total_next,
   output mfp_pkg::result_type   result
);

   localparam int WIDE     = ((SUM_BITS > TOTAL_BITS) ? SUM_BITS : TOTAL_BITS) + 1;
   localparam int OUT_WIDE = (TOTAL_BITS > 32) ? TOTAL_BITS : 32;

   logic [SUM_BITS:0]       chunk_add;
   logic [SUM_BITS-1:0]     chunk_sat;
   logic [WIDE-1:0]         chunk_wide;
   logic [WIDE-1:0]         total_wide;
   logic [WIDE-1:0]         total_plus;
   logic [WIDE-1:0]         total_max_wide;
   logic [TOTAL_BITS-1:0]   total_applied;
   logic [OUT_WIDE-1:0]     total_out_wide;
   logic [31:0]             total_out;
   logic                    meter_apply;
   logic                    level_emit;

   // Saturating chunk accumulate.
   assign chunk_add = {1'b0, chunk_sum} + (SUM_BITS+1)'(rx_byte);
   assign chunk_sat = chunk_add[SUM_BITS] ? {SUM_BITS{1'b1}} : chunk_add[SUM_BITS-1:0];

   // Apply the frame's signed sum to the total: clamp at 0, saturate at max.
   assign chunk_wide     = WIDE'(chunk_sum);
   assign total_wide     = WIDE'(running_total);
   assign total_plus     = total_wide + chunk_wide;
   assign total_max_wide = WIDE'({TOTAL_BITS{1'b1}});

   always_comb begin
      if (ctl.sign_minus) begin
         total_applied = (chunk_wide > total_wide) ? '0
                                                   : TOTAL_BITS'(total_wide - chunk_wide);
      end else begin
         total_applied = (total_plus > total_max_wide) ? {TOTAL_BITS{1'b1}}
                                                       : TOTAL_BITS'(total_plus);
      end
   end

   assign total_out_wide = OUT_WIDE'(total_applied);
   assign total_out = (total_out_wide > OUT_WIDE'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                  : 32'(total_applied);

   assign meter_apply = (ctl.mode == mfp_pkg::MODE_METER) &&
                        (rx_byte != mfp_pkg::BYTE_METER_EXIT) &&
                        (ctl.phase == mfp_pkg::PHASE_CHUNK) &&
                        (rx_byte == mfp_pkg::BYTE_FRAME_MARK) && !ctl.skip_next;

   assign level_emit = (ctl.mode == mfp_pkg::MODE_LEVEL) &&
                       (rx_byte == mfp_pkg::BYTE_LEVEL_EMIT) && (chunk_sum != '0);

   // Next state.
   always_comb begin
      ctl_next           = ctl;
      chunk_sum_next     = chunk_sum;
      running_total_next = running_total;
      case (ctl.mode)
         mfp_pkg::MODE_MENU: begin
            ctl_next.phase      = mfp_pkg::PHASE_WAIT_START;
            ctl_next.sign_minus = 1'b0;
            ctl_next.skip_next  = 1'b0;
            chunk_sum_next      = '0;
            running_total_next  = '0;
            if (rx_byte <= mfp_pkg::BYTE_MENU_MAX) begin
               ctl_next.mode = mfp_pkg::mode_type'(rx_byte[1:0]);
            end
         end
         mfp_pkg::MODE_METER: begin
            if (rx_byte == mfp_pkg::BYTE_METER_EXIT) begin
               ctl_next.mode = mfp_pkg::MODE_MENU;
            end else begin
               case (ctl.phase)
                  mfp_pkg::PHASE_WAIT_SIGN: begin
                     if (rx_byte == mfp_pkg::BYTE_SIGN_PLUS ||
                         rx_byte == mfp_pkg::BYTE_SIGN_MINUS) begin
                        ctl_next.sign_minus = (rx_byte == mfp_pkg::BYTE_SIGN_MINUS);
                        ctl_next.phase      = mfp_pkg::PHASE_CHUNK;
                     end
                  end
                  mfp_pkg::PHASE_CHUNK: begin
                     if (rx_byte == mfp_pkg::BYTE_FRAME_MARK) begin
                        if (!ctl.skip_next) begin
                           running_total_next = total_applied;
                        end
                        ctl_next.skip_next = !ctl.skip_next;
                        ctl_next.phase     = mfp_pkg::PHASE_WAIT_START;
                        chunk_sum_next     = '0;
                     end else begin
                        chunk_sum_next = chunk_sat;
                     end
                  end
                  default: begin
                     // Unused phase code behaves as waiting for start.
                     if (rx_byte == mfp_pkg::BYTE_FRAME_MARK) begin
                        ctl_next.phase = mfp_pkg::PHASE_WAIT_SIGN;
                     end
                  end
               endcase
            end
         end
         mfp_pkg::MODE_LEVEL: begin
            if (rx_byte == mfp_pkg::BYTE_LEVEL_EXIT) begin
               ctl_next.mode = mfp_pkg::MODE_MENU;
            end else if (rx_byte == mfp_pkg::BYTE_LEVEL_EMIT) begin
               if (chunk_sum != '0) begin
                  chunk_sum_next = '0;
               end
            end else begin
               chunk_sum_next = chunk_sat;
            end
         end
         default: begin
            if (rx_byte == mfp_pkg::BYTE_RANGER_EXIT) begin
               ctl_next.mode = mfp_pkg::MODE_MENU;
            end
         end
      endcase
   end

   // Result beat.
   always_comb begin
      result                = '0;
      result.mode           = ctl_next.mode;
      result.ranger_request = (ctl.mode == mfp_pkg::MODE_RANGER) &&
                              (rx_byte == mfp_pkg::BYTE_RANGER_REQ);
      if (meter_apply) begin
         result.measure_valid = 1'b1;
         result.measure_kind  = mfp_pkg::KIND_METER;
         result.measure_value = total_out;
      end else if (level_emit) begin
         result.measure_valid = 1'b1;
         result.measure_kind  = mfp_pkg::KIND_LEVEL;
         result.measure_value = 32'(chunk_sum);
      end
   end

endmodule

// ----- hw/rtl/measurement_frame_parser.sv -----
// measurement_frame_parser: top level with input register, parser state and result register.
// Depends on mfp_pkg and mfp_step.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  req_rx_byte
//   rsp_      out         rsp_valid / rsp_stall  rsp_mode, rsp_measure_valid,
//                                                rsp_measure_kind, rsp_measure_value,
//                                                rsp_ranger_request
//
// One byte per cycle sustained while rsp_stall is low; each byte yields exactly one result beat.
// A byte passes through the input register, then the step logic into the result register.
// The parser state updates in the cycle a byte moves into the result register.
// Reset clears mode, frame state, totals and both valid flags; no clearing pass.
// rsp_stall holds the result register and backs up into req_stall once the
// input register is also full.

module measurement_frame_parser #(
   parameter int SUM_BITS   = 24,
   parameter int TOTAL_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mfp_pkg::mode_type rsp_mode,
   output logic             rsp_measure_valid,
   output logic             rsp_measure_kind,
   output logic [31:0]      rsp_measure_value,
   output logic             rsp_ranger_request
);

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   advance;

   mfp_pkg::frame_ctl_type ctl_ff;
   mfp_pkg::frame_ctl_type ctl_in;
   logic [SUM_BITS-1:0]    chunk_sum_ff;
   logic [SUM_BITS-1:0]    chunk_sum_in;
   logic [TOTAL_BITS-1:0]  total_ff;
   logic [TOTAL_BITS-1:0]  total_in;

   mfp_pkg::result_type    result_in;
   mfp_pkg::result_type    result_ff;
   logic                   rsp_valid_ff;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   mfp_step #(
      .SUM_BITS   (SUM_BITS),
      .TOTAL_BITS (TOTAL_BITS)
   ) u_step (
      .rx_byte            (in_byte_ff),
      .ctl                (ctl_ff),
      .chunk_sum          (chunk_sum_ff),
      .running_total      (total_ff),
      .ctl_next           (ctl_in),
      .chunk_sum_next     (chunk_sum_in),
      .running_total_next (total_in),
      .result             (result_in)
   );

   // Commit state only when the beat moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.mode       <= mfp_pkg::MODE_MENU;
         ctl_ff.phase      <= mfp_pkg::PHASE_WAIT_START;
         ctl_ff.sign_minus <= 1'b0;
         ctl_ff.skip_next  <= 1'b0;
         chunk_sum_ff      <= '0;
         total_ff          <= '0;
      end else if (advance) begin
         ctl_ff       <= ctl_in;
         chunk_sum_ff <= chunk_sum_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mode           = result_ff.mode;
   assign rsp_measure_valid  = result_ff.measure_valid;
   assign rsp_measure_kind   = result_ff.measure_kind;
   assign rsp_measure_value  = result_ff.measure_value;
   assign rsp_ranger_request = result_ff.ranger_request;

   a_measure_mode : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_measure_valid) |->
         ((rsp_measure_kind == mfp_pkg::KIND_METER && rsp_mode == mfp_pkg::MODE_METER) ||
          (rsp_measure_kind == mfp_pkg::KIND_LEVEL && rsp_mode == mfp_pkg::MODE_LEVEL)))
      else $error("measurement beat does not match its mode");

   a_level_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_measure_valid && rsp_measure_kind == mfp_pkg::KIND_LEVEL) |->
         (rsp_measure_value != 32'd0))
      else $error("level measurement emitted with zero sum");

   a_ranger_mode : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ranger_request) |-> (rsp_mode == mfp_pkg::MODE_RANGER))
      else $error("ranger request outside ranger mode");

   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(ctl_ff) && $stable(chunk_sum_ff) && $stable(total_ff)))
      else $error("parser state changed without a beat advancing");

endmodule

// ----- tb/measurement_frame_parser_tb.sv -----
// measurement_frame_parser_tb: self-checking bench for the byte-driven mode parser.
// Drives bytes on the req_ channel and checks each rsp_ beat against a parser model or a typed row.
// Depends on mfp_pkg and measurement_frame_parser.

module measurement_frame_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SUM_BITS       = 24;
   localparam int TOTAL_BITS     = 32;
   localparam int RANDOM_BYTES   = 1296;
   localparam int LONG_RUN_BYTES = 24;
   localparam int HOLD_CYCLES    = 200;
   localparam int DRAIN_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 50000;

   typedef struct packed {
      mfp_pkg::mode_type mode;
      logic              mv;
      logic              kind;
      logic [31:0]       value;
      logic              ranger;
   } reading_type;

   typedef struct {
      logic [7:0]  rx;
      bit          typed;
      reading_type want;
   } byte_row_type;

   localparam reading_type NO_READING = '0;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_rx_byte = 8'd0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mfp_pkg::mode_type rsp_mode;
   logic              rsp_measure_valid;
   logic              rsp_measure_kind;
   logic [31:0]       rsp_measure_value;
   logic              rsp_ranger_request;

   // parser model state
   mfp_pkg::mode_type       st_mode = mfp_pkg::MODE_MENU;
   mfp_pkg::phase_type      st_phase = mfp_pkg::PHASE_WAIT_START;
   bit                      st_minus = 1'b0;
   logic [SUM_BITS-1:0]     st_chunk_sum = '0;
   logic [TOTAL_BITS-1:0]   st_total = '0;
   bit                      st_skip = 1'b0;

   reading_type pending_readings[$];
   int       send_idle_pct = 19;
   int       stall_pct = 19;
   bit       hold_go = 1'b0;
   logic     hold_on = 1'b0;
   int       mismatch_count = 0;
   int       bytes_sent = 0;
   int       meter_readings = 0;
   int       level_readings = 0;
   int       ranger_requests = 0;
   int       cycle_count = 0;

   // Typed rows hold results that follow directly from the frame rules.
   byte_row_type directed_rows [0:25] = '{
      '{8'd255, 1'b1, '{mfp_pkg::MODE_MENU, 1'b0, 1'b0, 32'd0, 1'b0}},
      '{8'd1,   1'b1, '{mfp_pkg::MODE_METER, 1'b0, 1'b0, 32'd0, 1'b0}},
      '{8'd7,   1'b0, NO_READING},
      '{8'd0,   1'b0, NO_READING},
      '{8'd9,   1'b0, NO_READING},
      '{8'd1,   1'b0, NO_READING},
      '{8'd255, 1'b0, NO_READING},
      '{8'd0,   1'b1, '{mfp_pkg::MODE_METER, 1'b1, mfp_pkg::KIND_METER, 32'd255, 1'b0}},
      '{8'd0,   1'b0, NO_READING},
      '{8'd2,   1'b0, NO_READING},
      '{8'd0,   1'b1, '{mfp_pkg::MODE_METER, 1'b0, 1'b0, 32'd0, 1'b0}},
      '{8'd0,   1'b0, NO_READING},
      '{8'd2,   1'b0, NO_READING},
      '{8'd255, 1'b0, NO_READING},
      '{8'd90,  1'b0, NO_READING},
      '{8'd0,   1'b1, '{mfp_pkg::MODE_METER, 1'b1, mfp_pkg::KIND_METER, 32'd0, 1'b0}},
      '{8'd3,   1'b1, '{mfp_pkg::MODE_MENU, 1'b0, 1'b0, 32'd0, 1'b0}},
      '{8'd2,   1'b1, '{mfp_pkg::MODE_LEVEL, 1'b0, 1'b0, 32'd0, 1'b0}},
      '{8'd128, 1'b0, NO_READING},
      '{8'd127, 1'b0, NO_READING},
      '{8'd50,  1'b1, '{mfp_pkg::MODE_LEVEL, 1'b1, mfp_pkg::KIND_LEVEL, 32'd255, 1'b0}},
      '{8'd50,  1'b1, '{mfp_pkg::MODE_LEVEL, 1'b0, 1'b0, 32'd0, 1'b0}},
      '{8'd100, 1'b1, '{mfp_pkg::MODE_MENU, 1'b0, 1'b0, 32'd0, 1'b0}},
      '{8'd3,   1'b1, '{mfp_pkg::MODE_RANGER, 1'b0, 1'b0, 32'd0, 1'b0}},
      '{8'd1,   1'b1, '{mfp_pkg::MODE_RANGER, 1'b0, 1'b0, 32'd0, 1'b1}},
      '{8'd2,   1'b1, '{mfp_pkg::MODE_MENU, 1'b0, 1'b0, 32'd0, 1'b0}}
   };

   measurement_frame_parser #(
      .SUM_BITS(SUM_BITS),
      .TOTAL_BITS(TOTAL_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_mode(rsp_mode),
      .rsp_measure_valid(rsp_measure_valid),
      .rsp_measure_kind(rsp_measure_kind),
      .rsp_measure_value(rsp_measure_value),
      .rsp_ranger_request(rsp_ranger_request)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                  pending_readings.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);

   // Long receiver hold-off: the parser fills up and backs into req_stall.
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   function automatic logic [SUM_BITS-1:0] add_chunk_sat(logic [SUM_BITS-1:0] s,
                                                          logic [7:0] b);
      logic [SUM_BITS:0] t;
      t = {1'b0, s} + (SUM_BITS+1)'(b);
      return t[SUM_BITS] ? '1 : t[SUM_BITS-1:0];
   endfunction

   // Advance the parser model by one byte and return the beat it produces.
   function automatic reading_type parse_byte(logic [7:0] b);
      reading_type         r;
      logic [TOTAL_BITS:0] t;
      r = NO_READING;
      case (st_mode)
         mfp_pkg::MODE_MENU: begin
            st_phase = mfp_pkg::PHASE_WAIT_START;
            st_minus = 1'b0;
            st_chunk_sum = '0;
            st_total = '0;
            st_skip = 1'b0;
            if (b <= mfp_pkg::BYTE_MENU_MAX) st_mode = mfp_pkg::mode_type'(b[1:0]);
         end
         mfp_pkg::MODE_METER: begin
            if (b == mfp_pkg::BYTE_METER_EXIT) begin
               st_mode = mfp_pkg::MODE_MENU;
            end else if (st_phase == mfp_pkg::PHASE_WAIT_SIGN) begin
               if (b == mfp_pkg::BYTE_SIGN_PLUS || b == mfp_pkg::BYTE_SIGN_MINUS) begin
                  st_minus = (b == mfp_pkg::BYTE_SIGN_MINUS);
                  st_phase = mfp_pkg::PHASE_CHUNK;
               end
            end else if (st_phase == mfp_pkg::PHASE_CHUNK) begin
               if (b == mfp_pkg::BYTE_FRAME_MARK) begin
                  if (!st_skip) begin
                     if (st_minus) begin
                        st_total = (TOTAL_BITS'(st_chunk_sum) > st_total) ? '0
                                   : st_total - TOTAL_BITS'(st_chunk_sum);
                     end else begin
                        t = {1'b0, st_total} + (TOTAL_BITS+1)'(st_chunk_sum);
                        st_total = t[TOTAL_BITS] ? '1 : t[TOTAL_BITS-1:0];
                     end
                     r.mv = 1'b1;
                     r.kind = mfp_pkg::KIND_METER;
                     r.value = 32'(st_total);
                  end
                  st_skip = !st_skip;
                  st_phase = mfp_pkg::PHASE_WAIT_START;
                  st_chunk_sum = '0;
               end else begin
                  st_chunk_sum = add_chunk_sat(st_chunk_sum, b);
               end
            end else if (b == mfp_pkg::BYTE_FRAME_MARK) begin
               st_phase = mfp_pkg::PHASE_WAIT_SIGN;
            end
         end
         mfp_pkg::MODE_LEVEL: begin
            if (b == mfp_pkg::BYTE_LEVEL_EXIT) begin
               st_mode = mfp_pkg::MODE_MENU;
            end else if (b == mfp_pkg::BYTE_LEVEL_EMIT) begin
               if (st_chunk_sum != '0) begin
                  r.mv = 1'b1;
                  r.kind = mfp_pkg::KIND_LEVEL;
                  r.value = 32'(st_chunk_sum);
                  st_chunk_sum = '0;
               end
            end else begin
               st_chunk_sum = add_chunk_sat(st_chunk_sum, b);
            end
         end
         default: begin
            if (b == mfp_pkg::BYTE_RANGER_REQ) r.ranger = 1'b1;
            else if (b == mfp_pkg::BYTE_RANGER_EXIT) st_mode = mfp_pkg::MODE_MENU;
         end
      endcase
      r.mode = st_mode;
      return r;
   endfunction

   // Mostly well-formed traffic for the current mode, with some raw noise.
   function automatic logic [7:0] pick_byte();
      logic [7:0] b;
      int         roll;
      roll = $urandom_range(99);
      b = 8'($urandom_range(255));
      if (roll < 8) return b;
      case (st_mode)
         mfp_pkg::MODE_MENU: begin
            if (roll < 90) b = 8'($urandom_range(1, 3));
            else if (roll < 93) b = mfp_pkg::BYTE_FRAME_MARK;
         end
         mfp_pkg::MODE_METER: begin
            case (st_phase)
               mfp_pkg::PHASE_WAIT_SIGN:
                  b = (roll < 60) ? mfp_pkg::BYTE_SIGN_PLUS : mfp_pkg::BYTE_SIGN_MINUS;
               mfp_pkg::PHASE_CHUNK: begin
                  if (roll < 30) begin
                     b = mfp_pkg::BYTE_FRAME_MARK;
                  end else if (roll < 33) begin
                     b = mfp_pkg::BYTE_METER_EXIT;
                  end else begin
                     b = 8'($urandom_range(1, 255));
                     if (b == mfp_pkg::BYTE_METER_EXIT) b = b + 8'd1;
                  end
               end
               default:
                  b = (roll < 95) ? mfp_pkg::BYTE_FRAME_MARK : mfp_pkg::BYTE_METER_EXIT;
            endcase
         end
         mfp_pkg::MODE_LEVEL: begin
            if (roll < 15) begin
               b = mfp_pkg::BYTE_LEVEL_EMIT;
            end else if (roll < 18) begin
               b = mfp_pkg::BYTE_LEVEL_EXIT;
            end else if (b == mfp_pkg::BYTE_LEVEL_EMIT || b == mfp_pkg::BYTE_LEVEL_EXIT) begin
               b = b + 8'd1;
            end
         end
         default: begin
            if (roll < 45) b = mfp_pkg::BYTE_RANGER_REQ;
            else if (roll < 53) b = mfp_pkg::BYTE_RANGER_EXIT;
         end
      endcase
      return b;
   endfunction

   // Offer one byte; on acceptance queue the beat it must produce.
   task automatic send_byte(input logic [7:0] b, input bit typed, input reading_type want);
      int          gap;
      bit          took;
      reading_type predicted;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      predicted = parse_byte(b);
      pending_readings.push_back(typed ? want : predicted);
      bytes_sent++;
   endtask

   task automatic report_mismatch(input string what, input reading_type want,
                                  input reading_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%0t %s: want mode %0d mv %0d kind %0d value %0d req %0d, ",
                   "got mode %0d mv %0d kind %0d value %0d req %0d"},
                  $realtime, what, want.mode, want.mv, want.kind, want.value, want.ranger,
                  got.mode, got.mv, got.kind, got.value, got.ranger);
   endtask

   // Sample at the falling edge: a beat seen here is taken at the next rising edge.
   always @(negedge clock) begin
      reading_type got;
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_mode, rsp_measure_valid, rsp_measure_kind, rsp_measure_value,
                rsp_ranger_request};
         if (pending_readings.size() == 0) begin
            report_mismatch("beat with nothing pending", NO_READING, got);
         end else begin
            want = pending_readings.pop_front();
            if (got.mode !== want.mode || got.mv !== want.mv || got.kind !== want.kind ||
                got.value !== want.value || got.ranger !== want.ranger)
               report_mismatch("field mismatch", want, got);
            if (want.mv && want.kind == mfp_pkg::KIND_METER) meter_readings++;
            if (want.mv && want.kind == mfp_pkg::KIND_LEVEL) level_readings++;
            if (want.ranger) ranger_requests++;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
               hold_go = 1'b1;
            end
            1: begin
               send_idle_pct = 45;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 45;
            end
            default: begin
               send_idle_pct = 19;
               stall_pct = 19;
            end
         endcase
         repeat (RANDOM_BYTES / 4) send_byte(pick_byte(), 1'b0, NO_READING);
      end

      // Return to menu, then build a long level sum of full-scale chunks.
      send_idle_pct = 0;
      stall_pct = 10;
      while (st_mode != mfp_pkg::MODE_MENU)
         case (st_mode)
            mfp_pkg::MODE_METER: send_byte(mfp_pkg::BYTE_METER_EXIT, 1'b0, NO_READING);
            mfp_pkg::MODE_LEVEL: send_byte(mfp_pkg::BYTE_LEVEL_EXIT, 1'b0, NO_READING);
            default:             send_byte(mfp_pkg::BYTE_RANGER_EXIT, 1'b0, NO_READING);
         endcase
      send_byte(8'd2, 1'b0, NO_READING);
      repeat (LONG_RUN_BYTES) send_byte(8'd255, 1'b0, NO_READING);
      send_byte(mfp_pkg::BYTE_LEVEL_EMIT, 1'b0, NO_READING);
      send_byte(mfp_pkg::BYTE_LEVEL_EXIT, 1'b0, NO_READING);

      req_valid <= 1'b0;
      stall_pct = 0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d bytes through all four modes under four idle/stall mixes,",
               bytes_sent);
      $display({"a long output hold-off and a long level run: ",
                "%0d meter totals, %0d level readings, %0d ranger requests"},
               meter_readings, level_readings, ranger_requests);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- measurement_frame_parser.f -----
hw/rtl/mfp_pkg.sv
hw/rtl/mfp_step.sv
hw/rtl/measurement_frame_parser.sv
tb/measurement_frame_parser_tb.sv
